FILE: sv/llsp_pkg.sv
// Shared types and constants for the least-loaded server picker.
// Holds the transaction structs, operation and status codes, FSM states and control structs.
// No dependencies.
`default_nettype none

package llsp_pkg;

  localparam int SERVERS   = 16;
  localparam int LOAD_BITS = 16;
  localparam int SLOT_BITS = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int IDX_W     = 4;
  localparam int THR_W     = 16;
  localparam int CMP_W     = (LOAD_BITS > THR_W) ? LOAD_BITS : THR_W;
  localparam int EXT_W     = SLOT_BITS + IDX_W;

  localparam logic [LOAD_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [THR_W-1:0]     THRESHOLD_RST = THR_W'(65534);

  typedef enum logic [1:0] {
    OP_DISPATCH  = 2'd0,
    OP_COMPLETE  = 2'd1,
    OP_SET_CLASS = 2'd2,
    OP_REGISTER  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] server_index;
    logic             is_inference;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_server;
    status_t          status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_DISP_WR,
    S_OP_RD,
    S_OP_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_op;
    logic scan_step;
    logic disp_commit;
    logic op_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic new_dispatch;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/llsp_ctrl.sv
// Controller FSM for the least-loaded server picker.
// Sequences the slot scan and the table updates; depends on llsp_pkg.
`default_nettype none

module llsp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire llsp_pkg::stat_t stat,
  output llsp_pkg::cmd_t      cmd
);
  import llsp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.new_dispatch ? S_SCAN : S_OP_RD;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: state_next = S_DISP_WR;
      S_DISP_WR:   state_next = S_FINISH;
      S_OP_RD:     state_next = S_OP_WR;
      S_OP_WR:     state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.rd_scan   = 1'b1;
        cmd.scan_step = 1'b1;
      end
      S_SCAN_LAST: ;
      S_DISP_WR:   cmd.disp_commit = 1'b1;
      S_OP_RD:     cmd.rd_op = 1'b1;
      S_OP_WR:     cmd.op_commit = 1'b1;
      S_FINISH:    cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  // A result is never loaded over one that is still waiting downstream.
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register busy");

  // One transaction at a time: the cycle after an accept the input stalls.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // The scan stops exactly after the last slot has been read.
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_last) |=> (state == S_SCAN_LAST))
    else $error("scan did not end at last slot");

  // Every dispatch commit follows the final compare of a scan.
  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.disp_commit |-> $past(state == S_SCAN_LAST))
    else $error("dispatch committed without a finished scan");

endmodule

`default_nettype wire

FILE: sv/llsp_dp.sv
// Datapath for the least-loaded server picker: slot table, count memory,
// scan compare, threshold register and output register. Depends on llsp_pkg.
`default_nettype none

module llsp_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire llsp_pkg::in_item_t         in_data,
  input  wire logic                       cfg_valid,
  input  wire logic [llsp_pkg::THR_W-1:0] cfg_data,
  input  wire llsp_pkg::cmd_t             cmd,
  output llsp_pkg::stat_t                 stat,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output llsp_pkg::out_item_t             out_data
);
  import llsp_pkg::*;

  logic [THR_W-1:0]     threshold;
  op_t                  op_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 cls_q;
  logic [SERVERS-1:0]   present;
  logic [SERVERS-1:0]   slot_class;
  logic [LOAD_BITS-1:0] count_mem [SERVERS];
  logic [LOAD_BITS-1:0] rd_data;
  logic                 rd_present;
  logic                 rd_class;
  logic [SLOT_BITS-1:0] scan_cnt;
  logic                 cmp_en;
  logic [SLOT_BITS-1:0] cmp_idx;
  logic                 found;
  logic [LOAD_BITS-1:0] best;
  logic [SLOT_BITS-1:0] pick;
  logic [IDX_W-1:0]     res_chosen;
  status_t              res_status;

  logic [EXT_W-1:0]     idx_ext;
  logic [EXT_W-1:0]     pick_ext;
  logic [SLOT_BITS-1:0] slot;
  logic                 idx_ok;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [LOAD_BITS-1:0] eff;
  logic                 eligible;
  logic                 we;
  logic [SLOT_BITS-1:0] waddr;
  logic [LOAD_BITS-1:0] wdata;

  always_comb begin
    idx_ext  = EXT_W'(idx_q);
    slot     = idx_ext[SLOT_BITS-1:0];
    idx_ok   = idx_ext < EXT_W'(SERVERS);
    pick_ext = EXT_W'(pick);
    rd_addr  = cmd.rd_scan ? scan_cnt : slot;
    // An absent slot reads as a zero count, whatever the memory contains.
    eff      = rd_present ? rd_data : '0;
    eligible = rd_present && (rd_class == cls_q)
               && (CMP_W'(rd_data) <= CMP_W'(threshold))
               && (!found || (rd_data < best));
  end

  always_comb begin
    we    = 1'b0;
    waddr = pick;
    wdata = (best == COUNT_MAX) ? best : best + 1'b1;
    if (cmd.disp_commit) begin
      we = found;
    end else if (cmd.op_commit && idx_ok) begin
      waddr = slot;
      if (op_q == OP_COMPLETE) begin
        we    = (eff != '0);
        wdata = eff - 1'b1;
      end else if (op_q == OP_REGISTER) begin
        we    = 1'b1;
        wdata = '0;
      end
    end
  end

  always_comb begin
    stat.new_dispatch = (in_data.op == OP_DISPATCH);
    stat.scan_last    = (scan_cnt == SLOT_BITS'(SERVERS - 1));
    stat.out_free     = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr] <= wdata;
    end
    if (cmd.rd_scan || cmd.rd_op) begin
      rd_data    <= count_mem[rd_addr];
      rd_present <= present[rd_addr];
      rd_class   <= slot_class[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present    <= '0;
      slot_class <= '0;
    end else if (cmd.op_commit && idx_ok) begin
      if (op_q == OP_REGISTER) begin
        present[slot] <= 1'b1;
      end
      if (op_q == OP_SET_CLASS) begin
        slot_class[slot] <= cls_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_scan;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (cmp_en && eligible) begin
        found <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= in_data.op;
      idx_q    <= in_data.server_index;
      cls_q    <= in_data.is_inference;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    cmp_idx <= scan_cnt;
    if (cmp_en && eligible) begin
      best <= rd_data;
      pick <= cmp_idx;
    end
    if (cmd.disp_commit) begin
      res_chosen <= found ? pick_ext[IDX_W-1:0] : '0;
      res_status <= found ? ST_OK : ST_NONE;
    end else if (cmd.op_commit) begin
      res_chosen <= '0;
      res_status <= ((op_q == OP_COMPLETE) && (!idx_ok || (eff == '0))) ? ST_ZERO : ST_OK;
    end
    if (cmd.out_load) begin
      out_data.chosen_server <= res_chosen;
      out_data.status        <= res_status;
    end
  end

endmodule

`default_nettype wire

FILE: sv/least_loaded_server_picker.sv
// Least-loaded server picker, top level: controller plus datapath.
// Dispatch: the count memory is scanned one slot per cycle, then the pick is committed and
// the result loaded; the next transaction is accepted only after the result is loaded.
// Complete, set class, register: read, write, then result loaded; one transaction at a time.
// Synchronous reset clears the slot table and output valid; threshold returns to 65534.
// Depends on llsp_pkg, llsp_ctrl and llsp_dp.
`default_nettype none

module least_loaded_server_picker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire llsp_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output llsp_pkg::out_item_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [llsp_pkg::THR_W-1:0] cfg_data
);
  import llsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  llsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  llsp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
